@@ hw/rtl/zcdh_pkg.sv @@
// zcdh_pkg: shared types and constants of the central directory header parser
// holds the front-to-back descriptor, field ids, error codes and the field layout
// depends on nothing
package zcdh_pkg;

  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_BLEN  = 2'd1;
  localparam logic [1:0] REG_MAXV  = 2'd2;

  localparam logic [31:0] CD_SIGNATURE = 32'h0201_4b50;
  localparam logic [5:0]  CD_FIXED_LEN = 6'd46;

  localparam logic [4:0] ID_REGION = 5'd16;
  localparam logic [4:0] ID_NEXT   = 5'd22;
  localparam logic [4:0] ID_ERROR  = 5'd23;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TRUNC = 2'd1;
  localparam logic [1:0] ERR_SIG   = 2'd2;
  localparam logic [1:0] ERR_VER   = 2'd3;

  // index of the field being assembled; zero is the signature
  localparam logic [4:0] F_SIG     = 5'd0;
  localparam logic [4:0] F_VER     = 5'd2;
  localparam logic [4:0] F_NAME    = 5'd10;
  localparam logic [4:0] F_EXTRA   = 5'd11;
  localparam logic [4:0] F_COMMENT = 5'd12;
  localparam logic [4:0] F_LAST    = 5'd16;

  // all results caused by one input byte
  typedef struct packed {
    logic        has_head;
    logic [4:0]  head_id;
    logic [31:0] head_val;
    logic [1:0]  head_err;
    logic [1:0]  nreg;
    logic [1:0]  tail_err;
    logic        has_next;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
  } desc_t;

  // byte count at which each field of the fixed part completes
  function automatic logic [5:0] field_end(input logic [4:0] idx);
    logic [5:0] e;
    unique case (idx)
      5'd0:    e = 6'd4;
      5'd1:    e = 6'd6;
      5'd2:    e = 6'd8;
      5'd3:    e = 6'd10;
      5'd4:    e = 6'd12;
      5'd5:    e = 6'd14;
      5'd6:    e = 6'd16;
      5'd7:    e = 6'd20;
      5'd8:    e = 6'd24;
      5'd9:    e = 6'd28;
      5'd10:   e = 6'd30;
      5'd11:   e = 6'd32;
      5'd12:   e = 6'd34;
      5'd13:   e = 6'd36;
      5'd14:   e = 6'd38;
      5'd15:   e = 6'd42;
      default: e = CD_FIXED_LEN;
    endcase
    return e;
  endfunction

endpackage

@@ hw/rtl/zip_central_directory_header_parser_unit.sv @@
// Central directory file header parser. Takes one archive byte per cycle (push/full) as long
// as the descriptor queue has room; bytes after an error are taken and dropped until reset.
// A byte causes zero to eight results, which leave through the output register (empty/pop) one
// per cycle while pop is held, so a stream of headers runs at one byte per cycle while the result
// sequencer keeps up; the last byte of a fixed part, which causes up to eight results, holds the
// sequencer until they have left, and the queue of QUEUE_DEPTH descriptors absorbs the burst.
// Configuration registers sit on an APB port: start offset at 0x0, buffer length at 0x4,
// maximum version at 0x8. Write them only while the block is idle.
// depends on zcdh_pkg, zcdh_front, zcdh_queue, zcdh_back
module zip_central_directory_header_parser_unit import zcdh_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_data_byte,
  output logic              empty,
  input  logic              pop,
  output logic [4:0]        out_field_id,
  output logic [31:0]       out_field_value,
  output logic [1:0]        out_error_code,
  output logic              out_last_of_run,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] start_r;
  logic [31:0] blen_r;
  logic [15:0] maxv_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        q_full, q_empty, q_pop, d_push;
  desc_t       d_front, q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      blen_r  <= '0;
      maxv_r  <= 16'd20;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START: start_r <= pwdata;
        REG_BLEN:  blen_r  <= pwdata;
        REG_MAXV:  maxv_r  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_START: prdata = start_r;
      REG_BLEN:  prdata = blen_r;
      REG_MAXV:  prdata = {16'b0, maxv_r};
      default:   prdata = '0;
    endcase
  end

  assign full = q_full;

  zcdh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (push && !q_full),
    .byte_data (in_data_byte),
    .start_wr  (cfg_wr && cfg_idx == REG_START),
    .start_val (pwdata),
    .blen      (blen_r),
    .maxv      (maxv_r),
    .desc_push (d_push),
    .desc      (d_front)
  );

  zcdh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (d_push && push && !q_full),
    .wdata (d_front),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  zcdh_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_field_id    (out_field_id),
    .out_field_value (out_field_value),
    .out_error_code  (out_error_code),
    .out_last_of_run (out_last_of_run)
  );

endmodule

@@ hw/rtl/zcdh_front.sv @@
// zcdh_front: byte classifier of the header parser
// tracks record position and fields, builds one descriptor per result-producing byte
// depends on zcdh_pkg
module zcdh_front import zcdh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_vld,
  input  logic [7:0]  byte_data,
  input  logic        start_wr,
  input  logic [31:0] start_val,
  input  logic [31:0] blen,
  input  logic [15:0] maxv,
  output logic        desc_push,
  output desc_t       desc
);

  localparam logic [1:0] PH_HDR  = 2'd0;
  localparam logic [1:0] PH_SKIP = 2'd1;
  localparam logic [1:0] PH_HALT = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] pos_r;
  logic [31:0] npos_r;
  logic [5:0]  hbc_r, hbc_nxt;
  logic [4:0]  fidx_r, fidx_nxt;
  logic [1:0]  kb_r, kb_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [15:0] name_r, name_nxt;
  logic [16:0] s2_r, s2_nxt;
  logic [17:0] s3_r, s3_nxt;
  logic [17:0] skip_r, skip_nxt;

  logic        trunc_first;
  logic [31:0] shift_acc;
  logic [5:0]  hbc_inc;
  logic [17:0] skip_dec;
  logic [32:0] e1, e2, e3;
  logic        fit1, fit2, fit3;

  assign trunc_first = ({1'b0, pos_r} + 33'(CD_FIXED_LEN)) > {1'b0, blen};
  assign shift_acc   = shift_r | ({24'b0, byte_data} << {kb_r, 3'b000});
  assign hbc_inc     = hbc_r + 6'd1;
  assign skip_dec    = skip_r - 18'd1;
  assign e1          = {1'b0, npos_r} + {17'b0, name_r};
  assign e2          = {1'b0, npos_r} + {16'b0, s2_r};
  assign e3          = {1'b0, npos_r} + {15'b0, s3_r};
  assign fit1        = e1 <= {1'b0, blen};
  assign fit2        = e2 <= {1'b0, blen};
  assign fit3        = e3 <= {1'b0, blen};

  always_comb begin
    phase_nxt = phase_r;
    hbc_nxt   = hbc_r;
    fidx_nxt  = fidx_r;
    kb_nxt    = kb_r;
    shift_nxt = shift_r;
    name_nxt  = name_r;
    s2_nxt    = s2_r;
    s3_nxt    = s3_r;
    skip_nxt  = skip_r;
    desc      = '0;
    desc_push = 1'b0;
    unique case (phase_r)
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt     = PH_HDR;
          desc.has_next = 1'b1;
          desc.a3       = npos_r;
          desc_push     = 1'b1;
        end
      end
      PH_HDR: begin
        if (hbc_r == '0 && trunc_first) begin
          phase_nxt     = PH_HALT;
          desc.has_head = 1'b1;
          desc.head_id  = ID_ERROR;
          desc.head_err = ERR_TRUNC;
          desc_push     = 1'b1;
        end else begin
          hbc_nxt   = hbc_inc;
          kb_nxt    = kb_r + 2'd1;
          shift_nxt = shift_acc;
          if (hbc_inc == field_end(fidx_r)) begin
            shift_nxt = '0;
            kb_nxt    = '0;
            fidx_nxt  = fidx_r + 5'd1;
            desc_push = 1'b1;
            if (fidx_r == F_SIG) begin
              if (shift_acc != CD_SIGNATURE) begin
                phase_nxt     = PH_HALT;
                desc.has_head = 1'b1;
                desc.head_id  = ID_ERROR;
                desc.head_err = ERR_SIG;
              end else begin
                desc_push = 1'b0;
              end
            end else begin
              desc.has_head = 1'b1;
              desc.head_id  = fidx_r - 5'd1;
              desc.head_val = shift_acc;
              if (fidx_r == F_VER && shift_acc > {16'b0, maxv}) begin
                phase_nxt     = PH_HALT;
                desc.tail_err = ERR_VER;
              end
              if (fidx_r == F_NAME) begin
                name_nxt = shift_acc[15:0];
              end
              if (fidx_r == F_EXTRA) begin
                s2_nxt = {1'b0, name_r} + {1'b0, shift_acc[15:0]};
              end
              if (fidx_r == F_COMMENT) begin
                s3_nxt = {1'b0, s2_r} + {2'b0, shift_acc[15:0]};
              end
              if (fidx_r == F_LAST) begin
                hbc_nxt  = '0;
                fidx_nxt = '0;
                desc.a0  = npos_r;
                desc.a1  = e1[31:0];
                desc.a2  = e2[31:0];
                desc.a3  = e3[31:0];
                if (!fit1) begin
                  desc.nreg = 2'd0;
                end else if (!fit2) begin
                  desc.nreg = 2'd1;
                end else if (!fit3) begin
                  desc.nreg = 2'd2;
                end else begin
                  desc.nreg = 2'd3;
                end
                if (!(fit1 && fit2 && fit3)) begin
                  phase_nxt     = PH_HALT;
                  desc.tail_err = ERR_TRUNC;
                end else if (s3_r == '0) begin
                  desc.has_next = 1'b1;
                end else begin
                  skip_nxt  = s3_r;
                  phase_nxt = PH_SKIP;
                end
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      pos_r   <= '0;
      npos_r  <= 32'd1;
      hbc_r   <= '0;
      fidx_r  <= '0;
      kb_r    <= '0;
      shift_r <= '0;
      name_r  <= '0;
      s2_r    <= '0;
      s3_r    <= '0;
      skip_r  <= '0;
    end else if (start_wr) begin
      pos_r  <= start_val;
      npos_r <= start_val + 32'd1;
    end else if (byte_vld) begin
      if (phase_r != PH_HALT) begin
        pos_r  <= npos_r;
        npos_r <= npos_r + 32'd1;
      end
      phase_r <= phase_nxt;
      hbc_r   <= hbc_nxt;
      fidx_r  <= fidx_nxt;
      kb_r    <= kb_nxt;
      shift_r <= shift_nxt;
      name_r  <= name_nxt;
      s2_r    <= s2_nxt;
      s3_r    <= s3_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

@@ hw/rtl/zcdh_queue.sv @@
// zcdh_queue: short descriptor queue between front and back
// register array with read and write pointers and a fill count
// depends on zcdh_pkg
module zcdh_queue import zcdh_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t wdata,
  output logic  full,
  input  logic  pop,
  output desc_t rdata,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t          mem_r [DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/zcdh_back.sv @@
// zcdh_back: result sequencer of the header parser
// expands each queued descriptor into output-register results, one per cycle while pop is held
// depends on zcdh_pkg
module zcdh_back import zcdh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  desc_t       q_head,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [4:0]  out_field_id,
  output logic [31:0] out_field_value,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run
);

  localparam int SLOTS = 9;

  logic             out_vld_r;
  logic [4:0]       id_r;
  logic [31:0]      val_r;
  logic [1:0]       err_r;
  logic             last_r;
  logic [SLOTS-1:0] done_r;

  logic [SLOTS-1:0] mask, rem, cur_oh, rem_after;
  logic [3:0]       sel;
  logic             load_ok, emit, last;
  logic [4:0]       id_nxt;
  logic [31:0]      val_nxt;
  logic [1:0]       err_nxt;

  assign mask = {q_head.has_next, q_head.tail_err != ERR_NONE,
                 {2{q_head.nreg >= 2'd3}}, {2{q_head.nreg >= 2'd2}},
                 {2{q_head.nreg >= 2'd1}}, q_head.has_head};
  assign rem  = mask & ~done_r;

  always_comb begin
    sel = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (rem[j]) begin
        sel = 4'(j);
      end
    end
  end

  assign cur_oh    = SLOTS'(1) << sel;
  assign rem_after = rem & ~cur_oh;
  assign last      = rem_after == '0;
  assign load_ok   = !out_vld_r || pop;
  assign emit      = load_ok && !q_empty;
  assign q_pop     = emit && last;

  always_comb begin
    id_nxt  = '0;
    val_nxt = '0;
    err_nxt = ERR_NONE;
    unique case (sel)
      4'd0: begin
        id_nxt  = q_head.head_id;
        val_nxt = q_head.head_val;
        err_nxt = q_head.head_err;
      end
      4'd1: begin
        id_nxt  = ID_REGION;
        val_nxt = q_head.a0;
      end
      4'd2: begin
        id_nxt  = ID_REGION + 5'd1;
        val_nxt = q_head.a1;
      end
      4'd3: begin
        id_nxt  = ID_REGION + 5'd2;
        val_nxt = q_head.a1;
      end
      4'd4: begin
        id_nxt  = ID_REGION + 5'd3;
        val_nxt = q_head.a2;
      end
      4'd5: begin
        id_nxt  = ID_REGION + 5'd4;
        val_nxt = q_head.a2;
      end
      4'd6: begin
        id_nxt  = ID_REGION + 5'd5;
        val_nxt = q_head.a3;
      end
      4'd7: begin
        id_nxt  = ID_ERROR;
        err_nxt = q_head.tail_err;
      end
      4'd8: begin
        id_nxt  = ID_NEXT;
        val_nxt = q_head.a3;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      done_r    <= '0;
    end else begin
      if (load_ok) begin
        out_vld_r <= emit;
      end
      if (emit) begin
        done_r <= last ? '0 : (done_r | cur_oh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      id_r   <= id_nxt;
      val_r  <= val_nxt;
      err_r  <= err_nxt;
      last_r <= last;
    end
  end

  assign empty           = !out_vld_r;
  assign out_field_id    = id_r;
  assign out_field_value = val_r;
  assign out_error_code  = err_r;
  assign out_last_of_run = last_r;

endmodule

@@ hw/rtl/zcdh_checker.sv @@
// zcdh_checker: port-level assertions for the header parser and its bind to the top level
// watches the result queue interface over time
// depends on zcdh_pkg and zip_central_directory_header_parser_unit
module zcdh_checker import zcdh_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [4:0]  out_field_id,
  input logic [31:0] out_field_value,
  input logic [1:0]  out_error_code,
  input logic        out_last_of_run
);

  // no result waits right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

  // a stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_field_id) && $stable(out_field_value)
      && $stable(out_error_code) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // an error result carries a code, no value, and closes its run
  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_field_id == ID_ERROR |->
      out_error_code != ERR_NONE && out_field_value == '0 && out_last_of_run)
    else $error("malformed error result");

  // only error results carry an error code
  a_code_only_err: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_field_id != ID_ERROR |-> out_error_code == ERR_NONE)
    else $error("error code on a field result");

  // nothing follows an error result
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && pop && out_field_id == ID_ERROR |=> empty)
    else $error("result after error");

endmodule

bind zip_central_directory_header_parser_unit zcdh_checker u_zcdh_checker (.*);

@@ test/tb.sv @@
// tb: self-checking bench for the central directory header parser unit
// streams archive bytes, predicts every emitted field and offset, checks them in order
// depends on zcdh_pkg and zip_central_directory_header_parser_unit
module tb;
  import zcdh_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [4:0]  id;
    logic [31:0] value;
    logic [1:0]  err;
    logic        last;
  } field_result_t;

  typedef enum {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;
  typedef enum {END_SHORT, END_REGION, END_SIG, END_VER} ending_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [7:0]        in_data_byte = 8'd0;
  logic              empty;
  logic              pop = 1'b0;
  logic [4:0]        out_field_id;
  logic [31:0]       out_field_value;
  logic [1:0]        out_error_code;
  logic              out_last_of_run;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = 32'd0;
  logic [31:0]       prdata;
  logic              pready;

  zip_central_directory_header_parser_unit dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_data_byte(in_data_byte),
    .empty(empty), .pop(pop),
    .out_field_id(out_field_id), .out_field_value(out_field_value),
    .out_error_code(out_error_code), .out_last_of_run(out_last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser mirror
  logic [31:0] cfg_blen = 32'd0;
  logic [15:0] cfg_maxv = 16'd20;
  logic [31:0] pos = 32'd0;
  logic [5:0]  hdr_cnt = 6'd0;
  logic [31:0] field_acc = 32'd0;
  logic [15:0] name_len = 16'd0;
  logic [15:0] extra_len = 16'd0;
  logic [15:0] comment_len = 16'd0;
  logic [17:0] skip_cnt = 18'd0;
  logic        skipping = 1'b0;
  logic        halted = 1'b0;
  logic [5:0]  fld_end [0:16] = '{6'd4, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd20,
                                  6'd24, 6'd28, 6'd30, 6'd32, 6'd34, 6'd36, 6'd38, 6'd42,
                                  6'd46};

  logic [7:0]    archive_bytes[$];
  field_result_t pending_fields[$];
  field_result_t byte_fields[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  records_sent = 0;
  int  bytes_taken = 0;
  int  cycles = 0;
  int  push_idle = 0;
  int  pop_idle = 0;
  bit  steady = 1'b0;

  function automatic void emit(input logic [4:0] id, input logic [31:0] value,
                               input logic [1:0] err);
    field_result_t r;
    r.id = id;
    r.value = value;
    r.err = err;
    r.last = 1'b0;
    byte_fields.push_back(r);
  endfunction

  function automatic void halt_with(input logic [1:0] err);
    emit(ID_ERROR, 32'd0, err);
    halted = 1'b1;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int unsigned idx;
    int unsigned k;
    logic [31:0] pos_now;
    logic [31:0] v;
    logic [63:0] base;
    logic [63:0] rend;
    logic [15:0] lens [0:2];
    logic [17:0] total;
    bit          fits;
    byte_fields.delete();
    if (halted) return;
    pos_now = pos;
    pos = pos + 32'd1;
    if (skipping) begin
      skip_cnt = skip_cnt - 18'd1;
      if (skip_cnt == 18'd0) begin
        skipping = 1'b0;
        emit(ID_NEXT, pos, ERR_NONE);
      end
    end else if (hdr_cnt == 6'd0 && {32'd0, pos_now} + 64'd46 > {32'd0, cfg_blen}) begin
      halt_with(ERR_TRUNC);
    end else begin
      idx = 0;
      while (idx < 16 && hdr_cnt >= fld_end[idx]) idx++;
      k = hdr_cnt - (idx == 0 ? 0 : fld_end[idx-1]);
      field_acc = field_acc | ({24'd0, b} << (8 * (k & 3)));
      hdr_cnt = hdr_cnt + 6'd1;
      if (hdr_cnt == fld_end[idx]) begin
        v = field_acc;
        field_acc = 32'd0;
        if (idx == F_SIG) begin
          if (v != CD_SIGNATURE) halt_with(ERR_SIG);
        end else begin
          emit(5'(idx - 1), v, ERR_NONE);
          if (idx == F_VER && v > {16'd0, cfg_maxv}) halt_with(ERR_VER);
          else if (idx == F_NAME) name_len = v[15:0];
          else if (idx == F_EXTRA) extra_len = v[15:0];
          else if (idx == F_COMMENT) comment_len = v[15:0];
        end
        if (!halted && idx == F_LAST) begin
          base = {32'd0, pos};
          hdr_cnt = 6'd0;
          lens[0] = name_len;
          lens[1] = extra_len;
          lens[2] = comment_len;
          fits = 1'b1;
          for (int j = 0; j < 3; j++) begin
            if (fits) begin
              rend = base + {48'd0, lens[j]};
              if (rend > {32'd0, cfg_blen}) begin
                halt_with(ERR_TRUNC);
                fits = 1'b0;
              end else begin
                emit(ID_REGION + 5'(2 * j), base[31:0], ERR_NONE);
                emit(ID_REGION + 5'(2 * j + 1), rend[31:0], ERR_NONE);
                base = rend;
              end
            end
          end
          if (fits) begin
            total = {2'd0, name_len} + {2'd0, extra_len} + {2'd0, comment_len};
            if (total == 18'd0) begin
              emit(ID_NEXT, pos, ERR_NONE);
            end else begin
              skip_cnt = total;
              skipping = 1'b1;
            end
          end
        end
      end
    end
    if (byte_fields.size() > 0) byte_fields[byte_fields.size()-1].last = 1'b1;
    foreach (byte_fields[j]) pending_fields.push_back(byte_fields[j]);
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // builds one header plus its regions and queues the bytes
  function automatic int add_record(input logic [31:0] sig, input logic [15:0] ver_need,
                                    input logic [15:0] nl, input logic [15:0] el,
                                    input logic [15:0] cl, input fill_t fill);
    logic [7:0] hdr [0:45];
    int         n;
    for (int j = 0; j < 46; j++) begin
      case (fill)
        FILL_ZERO: hdr[j] = 8'h00;
        FILL_ONES: hdr[j] = 8'hFF;
        default:   hdr[j] = 8'($urandom_range(0, 255));
      endcase
    end
    for (int j = 0; j < 4; j++) hdr[j] = sig[8*j +: 8];
    hdr[6] = ver_need[7:0];
    hdr[7] = ver_need[15:8];
    hdr[28] = nl[7:0];
    hdr[29] = nl[15:8];
    hdr[30] = el[7:0];
    hdr[31] = el[15:8];
    hdr[32] = cl[7:0];
    hdr[33] = cl[15:8];
    for (int j = 0; j < 46; j++) archive_bytes.push_back(hdr[j]);
    n = 46 + nl + el + cl;
    for (int j = 46; j < n; j++) archive_bytes.push_back(8'($urandom_range(0, 255)));
    records_sent++;
    return n;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] got;
    logic [31:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_START: pos = val;
      REG_BLEN:  cfg_blen = val;
      default:   cfg_maxv = val[15:0];
    endcase
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    want = (idx == REG_MAXV) ? {16'd0, val[15:0]} : val;
    check_field("register readback", want, got);
  endtask

  task automatic drain();
    while (archive_bytes.size() != 0 || pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // byte driver
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push_idle > 0) begin
      push_idle--;
      push <= 1'b0;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      push_idle = $urandom_range(0, 3);
      push <= 1'b0;
    end else if (archive_bytes.size() != 0) begin
      push <= 1'b1;
      in_data_byte <= archive_bytes[0];
    end else begin
      push <= 1'b0;
    end
  end

  // result consumer
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_idle > 0) begin
      pop_idle--;
      pop <= 1'b0;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      pop_idle = $urandom_range(0, 3);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // monitor: results first, then the byte taken at this edge
  always @(posedge clk) begin
    field_result_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        results_seen++;
        if (pending_fields.size() == 0) begin
          $display("%0t: unexpected transaction id %0d value %0h err %0d", $time,
                   out_field_id, out_field_value, out_error_code);
          mismatches++;
        end else begin
          want = pending_fields.pop_front();
          check_field("field_id", want.id, out_field_id);
          check_field("field_value", want.value, out_field_value);
          check_field("error_code", want.err, out_error_code);
          check_field("last_of_run", want.last, out_last_of_run);
        end
      end
      if (push && !full) begin
        bytes_taken++;
        parse_byte(in_data_byte);
        void'(archive_bytes.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] maxv;
    logic [31:0] start;
    logic [15:0] lens [0:2];
    int          bad_region;
    ending_t     ending;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty regions, version at the limit, extreme offsets and limits
    write_reg(REG_START, 32'hFFFF_FF00);
    write_reg(REG_BLEN, 32'hFFFF_FFFF);
    write_reg(REG_MAXV, 32'h0000_FFFF);
    void'(add_record(CD_SIGNATURE, 16'hFFFF, 16'd0, 16'd0, 16'd0, FILL_ONES));
    drain();

    // random record whose last region ends right at the buffer end
    maxv = 16'($urandom_range(0, 16'hFFFF));
    start = $urandom_range(0, 32'h0FFF_FFFF);
    for (int j = 0; j < 3; j++) lens[j] = 16'($urandom_range(1, 3));
    write_reg(REG_MAXV, {16'd0, maxv});
    write_reg(REG_START, start);
    write_reg(REG_BLEN, start + 32'd46 + {16'd0, lens[0]} + {16'd0, lens[1]}
                        + {16'd0, lens[2]});
    void'(add_record(CD_SIGNATURE, 16'($urandom_range(0, maxv)),
                     lens[0], lens[1], lens[2], FILL_RAND));
    drain();

    // one closing error, then bytes that must be ignored
    steady = 1'b1;
    ending = ending_t'($urandom_range(0, 3));
    start = $urandom_range(0, 32'hFFFF_0000);
    write_reg(REG_START, start);
    write_reg(REG_BLEN, 32'hFFFF_FFFF);
    write_reg(REG_MAXV, 32'd20);
    case (ending)
      END_SHORT: begin
        write_reg(REG_BLEN, start + $urandom_range(0, 45));
        archive_bytes.push_back(8'($urandom_range(0, 255)));
      end
      END_REGION: begin
        bad_region = $urandom_range(0, 2);
        for (int j = 0; j < 3; j++) lens[j] = (j == bad_region) ? 16'd10 : 16'd2;
        write_reg(REG_BLEN, start + 32'd50 + $urandom_range(0, 5));
        void'(add_record(CD_SIGNATURE, 16'd10, lens[0], lens[1], lens[2], FILL_RAND));
      end
      END_SIG: begin
        void'(add_record(CD_SIGNATURE ^ (32'd1 << $urandom_range(0, 31)), 16'd10,
                         16'd1, 16'd0, 16'd0, FILL_ZERO));
      end
      default: begin
        maxv = 16'($urandom_range(0, 16'hFFFE));
        write_reg(REG_MAXV, {16'd0, maxv});
        void'(add_record(CD_SIGNATURE, 16'($urandom_range(maxv + 1, 16'hFFFF)),
                         16'd1, 16'd1, 16'd1, FILL_RAND));
      end
    endcase
    repeat (8) archive_bytes.push_back(8'($urandom_range(0, 255)));
    drain();

    $display("%0d records, %0d archive bytes taken, %0d results checked",
             records_sent, bytes_taken, results_seen);
    $display("closing case %s, no output after the halt", ending.name());
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ zip_central_directory_header_parser_unit.f @@
hw/rtl/zcdh_pkg.sv
hw/rtl/zcdh_front.sv
hw/rtl/zcdh_queue.sv
hw/rtl/zcdh_back.sv
hw/rtl/zip_central_directory_header_parser_unit.sv
hw/rtl/zcdh_checker.sv
test/tb.sv
